// ----- design/aacrtp_pkg.sv -----
// ----------------------------------------------------------------------------
// aacrtp_pkg
// Shared constants, record codes and control structs of the AAC RTP
// access-unit packetizer.
// ----------------------------------------------------------------------------
package aacrtp_pkg;

  // Buffered frame slots and the widths that follow from them.
  localparam int AU_SLOTS  = 16;
  localparam int SLOT_W    = $clog2(AU_SLOTS);
  localparam int CNT_W     = $clog2(AU_SLOTS + 1);

  localparam int FSIZE_W   = 14;
  localparam int SIZE_W    = 13;
  localparam int TS_W      = 32;
  localparam int PAY_W     = 11;
  localparam int FRAMES_W  = 5;
  localparam int HB_W      = 9;
  localparam int ASZ_W     = 16;
  localparam int OFF_W     = 13;
  localparam int KIND_W    = 2;
  localparam int HDR_W     = 6;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam int ADTS_BYTES     = 7;
  localparam int FRAG_HDR_BYTES = 4;
  localparam int AU_HDR_BITS    = 2 * 8;
  localparam int PAYLOAD_FLOOR  = 260;
  localparam int FRAME_CAP      = 16;
  localparam int LIM_MAX        = (FRAME_CAP < AU_SLOTS) ? FRAME_CAP : AU_SLOTS;
  localparam int SIZE_CAP       = 8191;

  // Reset values of the configuration registers.
  localparam logic [PAY_W-1:0]    RST_MAX_PAYLOAD = PAY_W'(1460);
  localparam logic [FRAMES_W-1:0] RST_MAX_FRAMES  = FRAMES_W'(5);
  localparam logic                RST_STRIP_ADTS  = 1'b1;
  localparam logic [TS_W-1:0]     RST_MAX_DELAY   = '0;

  // Record kinds.
  localparam logic [KIND_W-1:0] KIND_AGG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AU   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRAG = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_MAX_FRAMES  = 2'd1;
  localparam logic [1:0] REG_STRIP_ADTS  = 2'd2;
  localparam logic [1:0] REG_MAX_DELAY   = 2'd3;

  typedef struct packed {
    logic [PAY_W-1:0]    max_payload_bytes;
    logic [FRAMES_W-1:0] max_frames;
    logic                strip_adts;
    logic [TS_W-1:0]     max_delay_ticks;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // capture the accepted item
    logic hdr;    // load the aggregated packet header record
    logic au;     // load one AU header record
    logic place;  // buffer the frame or set up fragmenting
    logic frag;   // load one fragment record
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flush;
    logic fits;
    logic au_last;
    logic frag_last;
    logic out_free;
  } status_t;

endpackage

// ----- design/aacrtp_regs.sv -----
// ----------------------------------------------------------------------------
// aacrtp_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module aacrtp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aacrtp_pkg::ADDR_W-1:0] paddr,
  input  logic [aacrtp_pkg::DATA_W-1:0] pwdata,
  output logic [aacrtp_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output aacrtp_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload_bytes <= aacrtp_pkg::RST_MAX_PAYLOAD;
      cfg.max_frames        <= aacrtp_pkg::RST_MAX_FRAMES;
      cfg.strip_adts        <= aacrtp_pkg::RST_STRIP_ADTS;
      cfg.max_delay_ticks   <= aacrtp_pkg::RST_MAX_DELAY;
    end else if (wr_en) begin
      unique case (reg_idx)
        aacrtp_pkg::REG_MAX_PAYLOAD:
          cfg.max_payload_bytes <= pwdata[aacrtp_pkg::PAY_W-1:0];
        aacrtp_pkg::REG_MAX_FRAMES:
          cfg.max_frames <= pwdata[aacrtp_pkg::FRAMES_W-1:0];
        aacrtp_pkg::REG_STRIP_ADTS:
          cfg.strip_adts <= pwdata[0];
        aacrtp_pkg::REG_MAX_DELAY:
          cfg.max_delay_ticks <= pwdata[aacrtp_pkg::TS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      aacrtp_pkg::REG_MAX_PAYLOAD: prdata = aacrtp_pkg::DATA_W'(cfg.max_payload_bytes);
      aacrtp_pkg::REG_MAX_FRAMES:  prdata = aacrtp_pkg::DATA_W'(cfg.max_frames);
      aacrtp_pkg::REG_STRIP_ADTS:  prdata = aacrtp_pkg::DATA_W'(cfg.strip_adts);
      aacrtp_pkg::REG_MAX_DELAY:   prdata = aacrtp_pkg::DATA_W'(cfg.max_delay_ticks);
    endcase
  end

endmodule

// ----- design/aacrtp_ctrl.sv -----
// ----------------------------------------------------------------------------
// aacrtp_ctrl
// Controller state machine: sequences evaluation, flush records, frame
// buffering and fragment records for one item at a time.
// ----------------------------------------------------------------------------
module aacrtp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  aacrtp_pkg::status_t   st,
  output aacrtp_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_AU    = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_FRAG  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = st.flush ? S_HDR : S_PLACE;
      end
      S_HDR: begin
        if (st.out_free) begin
          cmd.hdr    = 1'b1;
          state_next = S_AU;
        end
      end
      S_AU: begin
        if (st.out_free) begin
          cmd.au = 1'b1;
          if (st.au_last) begin
            state_next = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = st.fits ? S_IDLE : S_FRAG;
      end
      S_FRAG: begin
        if (st.out_free) begin
          cmd.frag = 1'b1;
          if (st.frag_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/aacrtp_dp.sv -----
// ----------------------------------------------------------------------------
// aacrtp_dp
// Datapath: buffered frame state, AU size store, fragment counters and the
// output record register.
// ----------------------------------------------------------------------------
module aacrtp_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  aacrtp_pkg::cfg_t                   cfg,
  input  aacrtp_pkg::cmd_t                   cmd,
  output aacrtp_pkg::status_t                st,
  input  logic [aacrtp_pkg::FSIZE_W-1:0]     frame_size,
  input  logic [aacrtp_pkg::TS_W-1:0]        frame_timestamp,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [aacrtp_pkg::KIND_W-1:0]      record_kind,
  output logic [aacrtp_pkg::HB_W-1:0]        au_headers_bits,
  output logic [aacrtp_pkg::ASZ_W-1:0]       au_size_bits,
  output logic [aacrtp_pkg::PAY_W-1:0]       payload_length,
  output logic [aacrtp_pkg::OFF_W-1:0]       fragment_offset,
  output logic                               marker,
  output logic [aacrtp_pkg::TS_W-1:0]        packet_timestamp,
  output logic                               last
);

  // Item being worked on.
  logic [aacrtp_pkg::SIZE_W-1:0] size_q;
  logic [aacrtp_pkg::TS_W-1:0]   ts_q;

  // Packet state.
  logic [aacrtp_pkg::CNT_W-1:0]  frame_count;
  logic [aacrtp_pkg::PAY_W-1:0]  data_bytes;
  logic [aacrtp_pkg::TS_W-1:0]   first_timestamp;
  logic [aacrtp_pkg::SIZE_W-1:0] au_size_store [aacrtp_pkg::AU_SLOTS];

  logic [aacrtp_pkg::SLOT_W-1:0] idx;
  logic [aacrtp_pkg::SIZE_W-1:0] left;
  logic [aacrtp_pkg::OFF_W-1:0]  off;

  // Effective limits derived from the registers.
  logic [aacrtp_pkg::PAY_W-1:0]    pay;
  logic [aacrtp_pkg::FRAMES_W-1:0] lim;
  logic [aacrtp_pkg::HDR_W-1:0]    hdr;
  logic [aacrtp_pkg::PAY_W-1:0]    cap;
  logic [aacrtp_pkg::PAY_W-1:0]    chunk;
  logic [aacrtp_pkg::FSIZE_W-1:0]  stripped;
  logic [aacrtp_pkg::SIZE_W-1:0]   size_in;
  logic [aacrtp_pkg::FSIZE_W-1:0]  need;
  logic [aacrtp_pkg::TS_W-1:0]     age;
  logic [aacrtp_pkg::SIZE_W-1:0]   len;
  logic                            load;

  always_comb begin
    pay = (cfg.max_payload_bytes < aacrtp_pkg::PAY_W'(aacrtp_pkg::PAYLOAD_FLOOR))
          ? aacrtp_pkg::PAY_W'(aacrtp_pkg::PAYLOAD_FLOOR) : cfg.max_payload_bytes;
    if (cfg.max_frames == '0) begin
      lim = aacrtp_pkg::FRAMES_W'(1);
    end else if (cfg.max_frames > aacrtp_pkg::FRAMES_W'(aacrtp_pkg::LIM_MAX)) begin
      lim = aacrtp_pkg::FRAMES_W'(aacrtp_pkg::LIM_MAX);
    end else begin
      lim = cfg.max_frames;
    end
    hdr   = aacrtp_pkg::HDR_W'(2) + {lim, 1'b0};
    cap   = pay - aacrtp_pkg::PAY_W'(hdr);
    chunk = pay - aacrtp_pkg::PAY_W'(aacrtp_pkg::FRAG_HDR_BYTES);

    // A short frame counts as empty when the ADTS header is removed.
    if (!cfg.strip_adts) begin
      stripped = frame_size;
    end else if (frame_size >= aacrtp_pkg::FSIZE_W'(aacrtp_pkg::ADTS_BYTES)) begin
      stripped = frame_size - aacrtp_pkg::FSIZE_W'(aacrtp_pkg::ADTS_BYTES);
    end else begin
      stripped = '0;
    end
    size_in = (stripped > aacrtp_pkg::FSIZE_W'(aacrtp_pkg::SIZE_CAP))
              ? aacrtp_pkg::SIZE_W'(aacrtp_pkg::SIZE_CAP)
              : stripped[aacrtp_pkg::SIZE_W-1:0];

    need = aacrtp_pkg::FSIZE_W'(hdr) + aacrtp_pkg::FSIZE_W'(data_bytes)
           + aacrtp_pkg::FSIZE_W'(size_q);
    age  = ts_q - first_timestamp;
    len  = (left < aacrtp_pkg::SIZE_W'(chunk)) ? left : aacrtp_pkg::SIZE_W'(chunk);

    st.flush     = (frame_count != '0) &&
                   ((frame_count >= lim) ||
                    (need > aacrtp_pkg::FSIZE_W'(pay)) ||
                    (age >= cfg.max_delay_ticks));
    st.fits      = size_q <= aacrtp_pkg::SIZE_W'(cap);
    st.au_last   = (aacrtp_pkg::CNT_W'(idx) + aacrtp_pkg::CNT_W'(1)) == frame_count;
    st.frag_last = left <= aacrtp_pkg::SIZE_W'(chunk);
    st.out_free  = !out_valid || !out_stall;
  end

  assign load = cmd.hdr | cmd.au | cmd.frag;

  // Control state and packet bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      frame_count     <= '0;
      data_bytes      <= '0;
      first_timestamp <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.au && st.au_last) begin
        frame_count <= '0;
      end

      if (cmd.place) begin
        if (st.fits) begin
          frame_count <= frame_count + aacrtp_pkg::CNT_W'(1);
          if (frame_count == '0) begin
            data_bytes      <= aacrtp_pkg::PAY_W'(size_q);
            first_timestamp <= ts_q;
          end else begin
            data_bytes <= data_bytes + aacrtp_pkg::PAY_W'(size_q);
          end
        end else begin
          // A fragmented frame always starts from an empty packet.
          data_bytes      <= '0;
          first_timestamp <= ts_q;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      size_q <= size_in;
      ts_q   <= frame_timestamp;
    end

    if (cmd.hdr) begin
      idx <= '0;
    end else if (cmd.au) begin
      idx <= idx + aacrtp_pkg::SLOT_W'(1);
    end

    if (cmd.place) begin
      if (st.fits) begin
        au_size_store[frame_count[aacrtp_pkg::SLOT_W-1:0]] <= size_q;
      end
      left <= size_q;
      off  <= '0;
    end else if (cmd.frag) begin
      left <= left - len;
      off  <= off + aacrtp_pkg::OFF_W'(len);
    end

    if (cmd.hdr) begin
      record_kind      <= aacrtp_pkg::KIND_AGG;
      au_headers_bits  <= aacrtp_pkg::HB_W'({frame_count, 4'b0000});
      au_size_bits     <= '0;
      payload_length   <= aacrtp_pkg::PAY_W'(
                            aacrtp_pkg::HDR_W'(2) + {aacrtp_pkg::HDR_W'(frame_count), 1'b0}
                            + {1'b0, data_bytes});
      fragment_offset  <= '0;
      marker           <= 1'b1;
      packet_timestamp <= first_timestamp;
      last             <= 1'b0;
    end else if (cmd.au) begin
      record_kind      <= aacrtp_pkg::KIND_AU;
      au_headers_bits  <= '0;
      au_size_bits     <= {au_size_store[idx], 3'b000};
      payload_length   <= '0;
      fragment_offset  <= '0;
      marker           <= 1'b0;
      packet_timestamp <= first_timestamp;
      last             <= st.au_last && st.fits;
    end else if (cmd.frag) begin
      record_kind      <= aacrtp_pkg::KIND_FRAG;
      au_headers_bits  <= aacrtp_pkg::HB_W'(aacrtp_pkg::AU_HDR_BITS);
      au_size_bits     <= {size_q, 3'b000};
      payload_length   <= aacrtp_pkg::PAY_W'(len + aacrtp_pkg::SIZE_W'(aacrtp_pkg::FRAG_HDR_BYTES));
      fragment_offset  <= off;
      marker           <= st.frag_last;
      packet_timestamp <= first_timestamp;
      last             <= st.frag_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    frame_count <= aacrtp_pkg::CNT_W'(aacrtp_pkg::AU_SLOTS))
    else $error("frame count beyond the AU slots");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.au && st.au_last) |=> (frame_count == '0))
    else $error("flush did not clear the frame count");

  a_frag_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.place && !st.fits) |-> (frame_count == '0))
    else $error("fragmenting with frames still buffered");

  a_frag_left: assert property (@(posedge clk) disable iff (rst)
    (cmd.frag && !st.frag_last) |=> (left != '0))
    else $error("fragment data ran out before the last fragment");

endmodule

// ----- design/aac_rtp_au_packetizer_unit.sv -----
// ----------------------------------------------------------------------------
// aac_rtp_au_packetizer_unit
// AAC access-unit packetizer for RTP: buffers frame descriptors and emits
// packet header, AU header and fragment records.
// ----------------------------------------------------------------------------
// Order: an item that flushes a packet goes from evaluation to the header state,
//   one that starts with a fragment through evaluation and placement to the
//   fragment state; a record load waits while the output register is stalled.
// Items: a flush loads a packet header and one AU header record per frame; a new
//   item is taken only in idle, and each record uses the single output register.
// Reset: synchronous rst clears the controller, the output valid flag, the
//   packet state and loads the register reset values; the AU store needs none.
module aac_rtp_au_packetizer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aacrtp_pkg::ADDR_W-1:0]      paddr,
  input  logic [aacrtp_pkg::DATA_W-1:0]      pwdata,
  output logic [aacrtp_pkg::DATA_W-1:0]      prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [aacrtp_pkg::FSIZE_W-1:0]     frame_size,
  input  logic [aacrtp_pkg::TS_W-1:0]        frame_timestamp,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [aacrtp_pkg::KIND_W-1:0]      record_kind,
  output logic [aacrtp_pkg::HB_W-1:0]        au_headers_bits,
  output logic [aacrtp_pkg::ASZ_W-1:0]       au_size_bits,
  output logic [aacrtp_pkg::PAY_W-1:0]       payload_length,
  output logic [aacrtp_pkg::OFF_W-1:0]       fragment_offset,
  output logic                               marker,
  output logic [aacrtp_pkg::TS_W-1:0]        packet_timestamp,
  output logic                               last
);

  aacrtp_pkg::cfg_t    cfg;
  aacrtp_pkg::cmd_t    cmd;
  aacrtp_pkg::status_t st;

  aacrtp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aacrtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  aacrtp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .st               (st),
    .frame_size       (frame_size),
    .frame_timestamp  (frame_timestamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .record_kind      (record_kind),
    .au_headers_bits  (au_headers_bits),
    .au_size_bits     (au_size_bits),
    .payload_length   (payload_length),
    .fragment_offset  (fragment_offset),
    .marker           (marker),
    .packet_timestamp (packet_timestamp),
    .last             (last)
  );

endmodule
